/* rtl/core/lsfd_pkg.sv */
// ----------------------------------------------------------------------------
// lsfd_pkg
// Types, constants and the byte-wide CRC-16 step shared by the leak sensor
// frame decoder.
// ----------------------------------------------------------------------------
package lsfd_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 18;
    localparam int unsigned IDX_W           = 5;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CRC_W           = 16;
    localparam int unsigned ID_W            = 32;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned RES_BITS        = STATUS_W + ID_W + 2;
    localparam int unsigned RES_TDATA_W     = ((RES_BITS + 7) / 8) * 8;

    localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'h0000;
    localparam logic [BYTE_W-1:0] ALARM_BIT     = 8'h80;
    localparam logic [BYTE_W-1:0] INV_ALARM_BIT = 8'h40;
    localparam logic [BYTE_W-1:0] BATTERY_BITS  = 8'h30;

    // frame byte positions
    localparam logic [IDX_W-1:0] POS_CHECK_LAST = 5'd1;
    localparam logic [IDX_W-1:0] POS_ID_FIRST   = 5'd2;
    localparam logic [IDX_W-1:0] POS_ID_LAST    = 5'd5;
    localparam logic [IDX_W-1:0] POS_CRC_LAST   = 5'd6;
    localparam logic [IDX_W-1:0] POS_FLAGS      = 5'd7;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_CRC_ERR   = 2'd2,
        STATUS_ALARM_ERR = 2'd3
    } status_t;

    typedef struct packed {
        logic              battery_low;
        logic              leak;
        logic [ID_W-1:0]   sensor_id;
        status_t           status;
    } result_t;

    // MSB-first CRC-16 over one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[CRC_W-1]) begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/core/lsfd_capture.sv */
// ----------------------------------------------------------------------------
// lsfd_capture
// Per-frame capture state: byte counter, CRC, check word, id and flags.
// Produces the frame verdict for the byte being stepped in.
// ----------------------------------------------------------------------------
module lsfd_capture #(
    parameter int unsigned FRAME_BYTES = lsfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [lsfd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          frame_start,
    input  logic                          frame_end,
    output lsfd_pkg::result_t             result
);

    localparam logic [lsfd_pkg::IDX_W-1:0] LAST_IDX = lsfd_pkg::IDX_W'(FRAME_BYTES);

    logic [lsfd_pkg::IDX_W-1:0]  idx_reg,   idx_next;
    logic [lsfd_pkg::CRC_W-1:0]  crc_reg,   crc_next;
    logic [lsfd_pkg::CRC_W-1:0]  check_reg, check_next;
    logic [lsfd_pkg::ID_W-1:0]   id_reg,    id_next;
    logic [lsfd_pkg::BYTE_W-1:0] flags_reg, flags_next;

    logic [lsfd_pkg::IDX_W-1:0]  pos;
    logic [lsfd_pkg::CRC_W-1:0]  crc_cur, check_cur, crc_upd, check_upd;
    logic [lsfd_pkg::ID_W-1:0]   id_cur, id_upd;
    logic [lsfd_pkg::BYTE_W-1:0] flags_cur, flags_upd;
    logic [lsfd_pkg::IDX_W-1:0]  idx_upd;
    logic                        alarm, alarm_inv;

    always_comb begin
        // a start byte sees cleared capture state
        pos       = frame_start ? '0 : idx_reg;
        crc_cur   = frame_start ? lsfd_pkg::CRC_INIT : crc_reg;
        check_cur = frame_start ? '0 : check_reg;
        id_cur    = frame_start ? '0 : id_reg;
        flags_cur = frame_start ? '0 : flags_reg;

        idx_upd   = pos;
        crc_upd   = crc_cur;
        check_upd = check_cur;
        id_upd    = id_cur;
        flags_upd = flags_cur;

        if (pos < LAST_IDX) begin
            if (pos <= lsfd_pkg::POS_CHECK_LAST) begin
                check_upd = {check_cur[lsfd_pkg::CRC_W-lsfd_pkg::BYTE_W-1:0], data_byte};
            end
            if (pos >= lsfd_pkg::POS_ID_FIRST && pos <= lsfd_pkg::POS_CRC_LAST) begin
                crc_upd = lsfd_pkg::crc_byte(crc_cur, data_byte);
            end
            if (pos >= lsfd_pkg::POS_ID_FIRST && pos <= lsfd_pkg::POS_ID_LAST) begin
                id_upd = {id_cur[lsfd_pkg::ID_W-lsfd_pkg::BYTE_W-1:0], data_byte};
            end
            if (pos == lsfd_pkg::POS_FLAGS) begin
                flags_upd = data_byte;
            end
            idx_upd = pos + 1'b1;
        end

        alarm     = |(flags_upd & lsfd_pkg::ALARM_BIT);
        alarm_inv = |(flags_upd & lsfd_pkg::INV_ALARM_BIT);

        result = '0;
        if (idx_upd < LAST_IDX) begin
            result.status = lsfd_pkg::STATUS_SHORT;
        end else if (crc_upd != check_upd) begin
            result.status = lsfd_pkg::STATUS_CRC_ERR;
        end else if (alarm == alarm_inv) begin
            result.status = lsfd_pkg::STATUS_ALARM_ERR;
        end else begin
            result.status      = lsfd_pkg::STATUS_OK;
            result.sensor_id   = id_upd;
            result.leak        = alarm;
            result.battery_low = ~|(flags_upd & lsfd_pkg::BATTERY_BITS);
        end

        // clear after the last byte so the next byte opens a new frame
        if (frame_end) begin
            idx_next   = '0;
            crc_next   = lsfd_pkg::CRC_INIT;
            check_next = '0;
            id_next    = '0;
            flags_next = '0;
        end else begin
            idx_next   = idx_upd;
            crc_next   = crc_upd;
            check_next = check_upd;
            id_next    = id_upd;
            flags_next = flags_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            crc_reg   <= lsfd_pkg::CRC_INIT;
            check_reg <= '0;
            id_reg    <= '0;
            flags_reg <= '0;
        end else if (step) begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            check_reg <= check_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
        end
    end

endmodule

/* rtl/core/leak_sensor_frame_decoder.sv */
// ----------------------------------------------------------------------------
// leak_sensor_frame_decoder
// Decodes CRC-16 checked leak sensor radio frames into status, id and flags.
// ----------------------------------------------------------------------------
// Feed the frame bytes that follow the sync word, one per word, with tuser
// marking the first byte and tlast the last. One result word leaves for each
// tlast byte, carrying the status (ok, too short, CRC mismatch, alarm bits
// agree) and, when ok, the sensor id, leak and battery-low flags. The block
// takes one byte every clock cycle unless a frame-end byte must wait for the
// result register to free up; a byte passes an input register and a result
// register, and m_tvalid rises as the last byte leaves the input register.
// The byte-wide CRC update and the frame checks sit between those two
// registers. While a result waits on m_tready, non-end bytes keep flowing.
module leak_sensor_frame_decoder #(
    parameter int unsigned FRAME_BYTES = lsfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lsfd_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] frame_start
    input  logic                                s_tlast,   // frame_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [33:2] sensor_id, [34] leak, [35] battery_low, [39:36] zero
    output logic [lsfd_pkg::RES_TDATA_W-1:0]    m_tdata
);

    logic                        in_valid_reg, in_valid_next;
    logic [lsfd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_start_reg;
    logic                        in_end_reg;
    logic                        out_valid_reg, out_valid_next;
    lsfd_pkg::result_t           out_res_reg;
    lsfd_pkg::result_t           frame_res;
    logic                        out_free;
    logic                        advance;

    lsfd_capture #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .frame_start (in_start_reg),
        .frame_end   (in_end_reg),
        .result      (frame_res)
    );

    // only a frame end needs room in the result register
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_end_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        if (advance && in_end_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_end_reg   <= s_tlast;
        end
        if (advance && in_end_reg) begin
            out_res_reg <= frame_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lsfd_pkg::RES_TDATA_W - lsfd_pkg::RES_BITS){1'b0}}, out_res_reg};

endmodule

/* sim/lsfd_frame_checker.sv */
// ----------------------------------------------------------------------------
// lsfd_frame_checker
// Watches both stream channels of the leak sensor frame decoder. It decodes
// each accepted frame byte with its own CRC-16 and field capture and queues
// the report that a frame end should produce. Each accepted result word is
// compared field by field with the oldest queued report.
// ----------------------------------------------------------------------------
module lsfd_frame_checker #(
    parameter int unsigned FRAME_BYTES = lsfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [lsfd_pkg::BYTE_W-1:0]         s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [lsfd_pkg::RES_TDATA_W-1:0]    m_tdata,
    output int                                  mismatches,
    output int                                  pending_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [lsfd_pkg::IDX_W-1:0]  frame_pos;
    logic [lsfd_pkg::CRC_W-1:0]  crc_run;
    logic [lsfd_pkg::CRC_W-1:0]  check_word;
    logic [lsfd_pkg::ID_W-1:0]   id_word;
    logic [lsfd_pkg::BYTE_W-1:0] flag_byte;

    lsfd_pkg::result_t expected_reports[$];
    int                err_total = 0;

    initial begin
        mismatches      = 0;
        pending_reports = 0;
    end

    // bit-serial form of the MSB-first CRC: feed one data bit per shift
    function automatic logic [lsfd_pkg::CRC_W-1:0] crc16_step(
            input logic [lsfd_pkg::CRC_W-1:0]  crc_in,
            input logic [lsfd_pkg::BYTE_W-1:0] b);
        logic [lsfd_pkg::CRC_W-1:0] c;
        logic                       fb;
        c = crc_in;
        for (int i = lsfd_pkg::BYTE_W - 1; i >= 0; i--) begin
            fb = c[lsfd_pkg::CRC_W-1] ^ b[i];
            c  = {c[lsfd_pkg::CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ lsfd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic restart_capture();
        frame_pos  = '0;
        crc_run    = lsfd_pkg::CRC_INIT;
        check_word = '0;
        id_word    = '0;
        flag_byte  = '0;
    endtask

    task automatic decode_frame_byte(input logic [lsfd_pkg::BYTE_W-1:0] b,
                                     input logic is_start, input logic is_end);
        lsfd_pkg::result_t rpt;
        logic              alarm;
        logic              alarm_inv;
        if (is_start) begin
            restart_capture();
        end
        // bytes past the frame length are dropped; the position saturates
        if (frame_pos < FRAME_BYTES) begin
            if (frame_pos < 2) begin
                check_word = {check_word[7:0], b};
            end
            if (frame_pos >= 2 && frame_pos <= 6) begin
                crc_run = crc16_step(crc_run, b);
            end
            if (frame_pos >= 2 && frame_pos <= 5) begin
                id_word = {id_word[23:0], b};
            end
            if (frame_pos == 7) begin
                flag_byte = b;
            end
            frame_pos = frame_pos + 1'b1;
        end
        if (is_end) begin
            alarm     = |(flag_byte & lsfd_pkg::ALARM_BIT);
            alarm_inv = |(flag_byte & lsfd_pkg::INV_ALARM_BIT);
            rpt       = '0;
            if (frame_pos < FRAME_BYTES) begin
                rpt.status = lsfd_pkg::STATUS_SHORT;
            end else if (crc_run != check_word) begin
                rpt.status = lsfd_pkg::STATUS_CRC_ERR;
            end else if (alarm == alarm_inv) begin
                rpt.status = lsfd_pkg::STATUS_ALARM_ERR;
            end else begin
                rpt.status      = lsfd_pkg::STATUS_OK;
                rpt.sensor_id   = id_word;
                rpt.leak        = alarm;
                rpt.battery_low = ((flag_byte & lsfd_pkg::BATTERY_BITS) == '0);
            end
            expected_reports.push_back(rpt);
            restart_capture();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin
        lsfd_pkg::result_t want;
        lsfd_pkg::result_t got;
        if (!aresetn) begin
            restart_capture();
            expected_reports.delete();
        end else begin
            // results first, so a word in this cycle never meets a report
            // queued by a byte taken in the same cycle
            if (m_tvalid && m_tready) begin
                got = lsfd_pkg::result_t'(m_tdata[lsfd_pkg::RES_BITS-1:0]);
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, actual %h",
                             $time, m_tdata);
                    err_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("sensor_id", want.sensor_id, got.sensor_id);
                    check_field("leak", 32'(want.leak), 32'(got.leak));
                    check_field("battery_low", 32'(want.battery_low),
                                32'(got.battery_low));
                    check_field("pad bits", 32'd0,
                                32'(m_tdata >> lsfd_pkg::RES_BITS));
                end
            end
            if (s_tvalid && s_tready) begin
                decode_frame_byte(s_tdata, s_tuser, s_tlast);
            end
        end
        mismatches      <= err_total;
        pending_reports <= expected_reports.size();
    end

endmodule

/* sim/leak_sensor_frame_decoder_tb.sv */
// ----------------------------------------------------------------------------
// leak_sensor_frame_decoder_tb
// Feeds the frame decoder a few hand-built frames, then random frames of
// every kind (good, missing start mark, alarm bits agreeing, corrupted CRC,
// short, overlong, restarted after noise) across phases of sender idling
// and receiver stalls, including one long receiver hold-off. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module leak_sensor_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_BYTES = lsfd_pkg::FRAME_BYTES_DEF;
    localparam int          HOLD_CYCLES = 300;

    typedef enum int {
        FR_GOOD,
        FR_NO_START,
        FR_ALARM_AGREE,
        FR_BAD_CRC,
        FR_SHORT,
        FR_LONG,
        FR_RESTART
    } frame_kind_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lsfd_pkg::BYTE_W-1:0]      s_tdata  = '0;    // [7:0] data_byte
    logic                             s_tuser  = 1'b0;  // [0] frame_start
    logic                             s_tlast  = 1'b0;  // frame_end
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // [1:0] status, [33:2] sensor_id, [34] leak, [35] battery_low, [39:36] zero
    logic [lsfd_pkg::RES_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending_reports;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int phase_bytes   = 0;
    int phase_reports = 0;

    leak_sensor_frame_decoder #(.FRAME_BYTES(FRAME_BYTES)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lsfd_frame_checker #(.FRAME_BYTES(FRAME_BYTES)) frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending_reports (pending_reports)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #400000;
        $display("leak_sensor_frame_decoder_tb: FAIL");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // offer one word and hold it until taken; tvalid stays high afterwards
    task automatic send_byte(input logic [7:0] b, input logic is_start,
                             input logic is_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= is_start;
        s_tlast  <= is_end;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        phase_bytes++;
        if (is_end) begin
            phase_reports++;
        end
    endtask

    task automatic send_frame(input frame_kind_t kind, input logic [31:0] id,
                              input logic [7:0] flags);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          pos;
        int          len;
        fb = {8'h00, 8'h00, id[31:24], id[23:16], id[15:8], id[7:0], rand_byte(), flags};
        repeat (FRAME_BYTES - 8) fb.push_back(rand_byte());
        crc = lsfd_pkg::CRC_INIT;
        for (int i = 2; i <= 6; i++) begin
            crc = lsfd_pkg::crc_byte(crc, fb[i]);
        end
        fb[0] = crc[15:8];
        fb[1] = crc[7:0];
        case (kind)
            FR_BAD_CRC: begin
                // any single flipped bit in the check word or the covered bytes
                pos     = $urandom_range(6);
                fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(7));
            end
            FR_SHORT: begin
                len = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, FRAME_BYTES - 1);
                while (fb.size() > len) fb.pop_back();
            end
            FR_LONG: begin
                repeat ($urandom_range(1, 22)) fb.push_back(rand_byte());
            end
            FR_RESTART: begin
                repeat ($urandom_range(1, 12)) begin
                    send_byte(rand_byte(), 1'($urandom_range(1)), 1'b0);
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < fb.size(); i++) begin
            send_byte(fb[i], (i == 0) && (kind != FR_NO_START), i == fb.size() - 1);
        end
    endtask

    task automatic send_random_frame();
        frame_kind_t kind;
        logic [31:0] id;
        logic [7:0]  flags;
        int          r;
        r = $urandom_range(99);
        if (r < 40) begin
            kind = FR_GOOD;
        end else if (r < 50) begin
            kind = FR_NO_START;
        end else if (r < 60) begin
            kind = FR_ALARM_AGREE;
        end else if (r < 70) begin
            kind = FR_BAD_CRC;
        end else if (r < 82) begin
            kind = FR_SHORT;
        end else if (r < 91) begin
            kind = FR_LONG;
        end else begin
            kind = FR_RESTART;
        end
        case ($urandom_range(7))
            0:       id = 32'h0000_0000;
            1:       id = 32'hFFFF_FFFF;
            default: id = $urandom;
        endcase
        flags    = rand_byte();
        flags[6] = (kind == FR_ALARM_AGREE) ? flags[7] : ~flags[7];
        send_frame(kind, id, flags);
    endtask

    // drop tvalid and wait until every queued report has been delivered
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_reports == 0);
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // counted from reset without a start mark: leak set, battery low
        send_frame(FR_NO_START, 32'hFFFF_FFFF, 8'h80);
        // start and end on the same byte
        send_byte(8'hFF, 1'b1, 1'b1);
        // three-byte frame
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        drain_reports();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_req      = 1'b1;
                end
                1: begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default: begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            phase_bytes   = 0;
            phase_reports = 0;
            while (phase_bytes < 100 || phase_reports < 10) begin
                send_random_frame();
            end
            drain_reports();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_reports == 0) begin
            $display("leak_sensor_frame_decoder_tb: PASS");
        end else begin
            $display("leak_sensor_frame_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
